### src/c1w_pkg.sv
package c1w_pkg;

  // Action codes
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_FWD  = 2'd1;
  localparam logic [1:0] ACT_BACK = 2'd2;

  localparam int unsigned HALF_W = 24;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_W  = 48;

  // LFSR feedback taps per half
  localparam logic [HALF_W-1:0] POLY_ODD  = 24'h29CE5C;
  localparam logic [HALF_W-1:0] POLY_EVEN = 24'h870804;

  // Filter tables: first-level nibble functions and the 5-input output function
  localparam logic [31:0] FILT_A   = 32'h000F22C0;
  localparam logic [31:0] FILT_B   = 32'h0006C9C0;
  localparam logic [31:0] FILT_C   = 32'h0003C8B0;
  localparam logic [31:0] FILT_D   = 32'h0001E458;
  localparam logic [31:0] FILT_E   = 32'h0000D938;
  localparam logic [31:0] FILT_OUT = 32'hEC57E80A;

  typedef struct packed {
    logic [HALF_W-1:0] odd_half;
    logic [HALF_W-1:0] even_half;
  } lfsr_t;

  // Nonlinear filter over the odd half
  function automatic logic c1w_filt(input logic [HALF_W-1:0] v);
    logic [4:0] f;
    f[4] = FILT_A[5'(v[3:0])   + 5'd4];
    f[3] = FILT_B[5'(v[7:4])   + 5'd3];
    f[2] = FILT_C[5'(v[11:8])  + 5'd2];
    f[1] = FILT_D[5'(v[15:12]) + 5'd1];
    f[0] = FILT_E[5'(v[19:16])];
    return FILT_OUT[f];
  endfunction

  // Interleave the halves into key bit order
  function automatic logic [KEY_W-1:0] c1w_key_form(input lfsr_t s);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < HALF_W; i++) begin
      k[2*i+1] = s.odd_half[5'(i) ^ 5'd3];
      k[2*i]   = s.even_half[5'(i) ^ 5'd3];
    end
    return k;
  endfunction

  // Spread a key into the two halves
  function automatic lfsr_t c1w_key_load(input logic [KEY_W-1:0] k);
    lfsr_t s;
    for (int i = 0; i < HALF_W; i++) begin
      s.odd_half[5'(i) ^ 5'd3]  = k[2*i+1];
      s.even_half[5'(i) ^ 5'd3] = k[2*i];
    end
    return s;
  endfunction

endpackage

### src/c1w_core.sv
// One word of cipher work: key load, 32 forward steps or 32 rollback steps; an unused action holds the state.
module c1w_core
  import c1w_pkg::*;
(
  input  logic [1:0]        action_i,
  input  logic [WORD_W-1:0] data_in_i,
  input  logic              feed_back_i,
  input  logic [KEY_W-1:0]  key_in_i,
  input  lfsr_t             state_i,
  output lfsr_t             state_o,
  output logic [WORD_W-1:0] keystream_o
);

  always_comb begin
    logic [HALF_W-1:0] odd;
    logic [HALF_W-1:0] even;
    logic [HALF_W-1:0] tmp;
    logic [4:0]        idx;
    logic              f;
    logic              p;
    odd         = state_i.odd_half;
    even        = state_i.even_half;
    tmp         = '0;
    idx         = '0;
    f           = 1'b0;
    p           = 1'b0;
    keystream_o = '0;
    state_o     = state_i;
    case (action_i)
      ACT_LOAD: begin
        state_o = c1w_key_load(key_in_i);
      end
      ACT_FWD: begin
        // bit i of the word order maps to data bit i^24 (byte swap)
        for (int i = 0; i < WORD_W; i++) begin
          idx = 5'(i) ^ 5'd24;
          f   = c1w_filt(odd);
          p   = (f & feed_back_i) ^ (^(even & POLY_EVEN)) ^ (^(odd & POLY_ODD))
                ^ data_in_i[idx];
          keystream_o[idx] = f;
          tmp  = {even[HALF_W-2:0], p};
          even = odd;
          odd  = tmp;
        end
        state_o.odd_half  = odd;
        state_o.even_half = even;
      end
      ACT_BACK: begin
        // exact inverse of the forward step, last bit first
        for (int i = WORD_W - 1; i >= 0; i--) begin
          idx  = 5'(i) ^ 5'd24;
          tmp  = odd;
          odd  = even;
          even = tmp;
          f    = c1w_filt(odd);
          p    = (f & feed_back_i) ^ even[0];
          even = {1'b0, even[HALF_W-1:1]};
          p    = p ^ (^(even & POLY_EVEN)) ^ (^(odd & POLY_ODD)) ^ data_in_i[idx];
          even[HALF_W-1]   = p;
          keystream_o[idx] = f;
        end
        state_o.odd_half  = odd;
        state_o.even_half = even;
      end
      default: begin
        // unused action: state holds, keystream zero
        state_o = state_i;
      end
    endcase
  end

endmodule

### src/crypto1_word_cipher.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o  | action_i, data_in_i, feed_back_i, key_in_i
// out     | output    | out_valid_o / out_ready_i| keystream_o, state_out_o
//
// One word per cycle sustained while the output is not stalled.
// The input register feeds the 32-step unrolled LFSR logic, which updates
// the cipher state and the result register in the same cycle.
// Reset clears both LFSR halves and the valid flags.
// A stalled output holds the result; the input stage then holds one more
// transaction and deasserts in_ready_o.
module crypto1_word_cipher
  import c1w_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [WORD_W-1:0] data_in_i,
  input  logic              feed_back_i,
  input  logic [KEY_W-1:0]  key_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] keystream_o,
  output logic [KEY_W-1:0]  state_out_o
);

  logic              in_valid_q;
  logic [1:0]        action_q;
  logic [WORD_W-1:0] data_q;
  logic              feed_back_q;
  logic [KEY_W-1:0]  key_q;

  lfsr_t             state_q;
  lfsr_t             state_d;
  logic [WORD_W-1:0] ks_d;

  logic              out_valid_q;
  logic [WORD_W-1:0] keystream_q;
  logic [KEY_W-1:0]  state_out_q;

  logic              advance;

  // Stage 1 moves on when the result register is free or being drained
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q    <= action_i;
      data_q      <= data_in_i;
      feed_back_q <= feed_back_i;
      key_q       <= key_in_i;
    end
  end

  // Word step
  c1w_core u_core (
    .action_i    (action_q),
    .data_in_i   (data_q),
    .feed_back_i (feed_back_q),
    .key_in_i    (key_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .keystream_o (ks_d)
  );

  // Cipher state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      keystream_q <= ks_d;
      state_out_q <= c1w_key_form(state_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign keystream_o = keystream_q;
  assign state_out_o = state_out_q;

  // A key load always yields an all-zero keystream
  a_load_zero_ks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q && action_q == ACT_LOAD |=> keystream_o == '0)
    else $error("load produced nonzero keystream");

  // The cipher state only changes when a transaction enters the result stage
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && in_valid_q) |=> $stable(state_q))
    else $error("state changed without a transaction");

  // The result shown matches the current cipher state
  a_state_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_out_q == c1w_key_form(state_q))
    else $error("result state out of step with LFSR");

  // An empty result register never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

### verif/crypto1_word_checker.sv
module crypto1_word_checker
  import c1w_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        action_i,
  input  logic [WORD_W-1:0] data_in_i,
  input  logic              feed_back_i,
  input  logic [KEY_W-1:0]  key_in_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [WORD_W-1:0] keystream_i,
  input  logic [KEY_W-1:0]  state_out_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);

  typedef struct packed {
    logic [WORD_W-1:0] keystream;
    logic [KEY_W-1:0]  state_key;
  } word_result_t;

  typedef struct packed {
    logic [WORD_W-1:0] keystream;
    lfsr_t             lfsr;
  } word_step_t;

  word_result_t expected_q[$];
  word_result_t want;
  word_step_t   step;
  lfsr_t        cipher_state;

  // Two-level nonlinear filter over bits 19:0 of the odd half
  function automatic logic filter_bit(input logic [HALF_W-1:0] v);
    logic [4:0] sel;
    sel[4] = FILT_A[int'(v[3:0]) + 4];
    sel[3] = FILT_B[int'(v[7:4]) + 3];
    sel[2] = FILT_C[int'(v[11:8]) + 2];
    sel[1] = FILT_D[int'(v[15:12]) + 1];
    sel[0] = FILT_E[int'(v[19:16])];
    return FILT_OUT[sel];
  endfunction

  // One forward LFSR clock
  function automatic lfsr_t step_forward(input lfsr_t s, input logic din, input logic fbk);
    lfsr_t n;
    logic  nb;
    nb = (filter_bit(s.odd_half) & fbk) ^ (^(s.even_half & POLY_EVEN))
         ^ (^(s.odd_half & POLY_ODD)) ^ din;
    n.odd_half  = {s.even_half[HALF_W-2:0], nb};
    n.even_half = s.odd_half;
    return n;
  endfunction

  // Inverse of step_forward: recover the bit that fell off the even half
  function automatic lfsr_t step_back(input lfsr_t s, input logic din, input logic fbk);
    lfsr_t n;
    logic  nb;
    n.odd_half  = s.even_half;
    n.even_half = s.odd_half >> 1;
    nb = (filter_bit(n.odd_half) & fbk) ^ s.odd_half[0] ^ (^(n.even_half & POLY_EVEN))
         ^ (^(n.odd_half & POLY_ODD)) ^ din;
    n.even_half[HALF_W-1] = nb;
    return n;
  endfunction

  function automatic lfsr_t spread_key(input logic [KEY_W-1:0] k);
    lfsr_t s;
    for (int i = 0; i < HALF_W; i++) begin
      s.odd_half[i ^ 3]  = k[2*i+1];
      s.even_half[i ^ 3] = k[2*i];
    end
    return s;
  endfunction

  function automatic logic [KEY_W-1:0] gather_key(input lfsr_t s);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < HALF_W; i++) begin
      k[2*i+1] = s.odd_half[i ^ 3];
      k[2*i]   = s.even_half[i ^ 3];
    end
    return k;
  endfunction

  // Whole-word effect of one transaction; bits are taken in byte-swapped order
  function automatic word_step_t cipher_word(input lfsr_t s, input logic [1:0] act,
                                             input logic [WORD_W-1:0] data,
                                             input logic fbk, input logic [KEY_W-1:0] key);
    word_step_t r;
    int         b;
    r.keystream = '0;
    r.lfsr      = s;
    case (act)
      ACT_LOAD: begin
        r.lfsr = spread_key(key);
      end
      ACT_FWD: begin
        for (int i = 0; i < WORD_W; i++) begin
          b = i ^ 24;
          r.keystream[b] = filter_bit(r.lfsr.odd_half);
          r.lfsr = step_forward(r.lfsr, data[b], fbk);
        end
      end
      ACT_BACK: begin
        for (int i = WORD_W - 1; i >= 0; i--) begin
          b = i ^ 24;
          r.keystream[b] = filter_bit(r.lfsr.even_half);
          r.lfsr = step_back(r.lfsr, data[b], fbk);
        end
      end
      default: begin
        // unused action: state held, keystream zero
      end
    endcase
    return r;
  endfunction

  // Compare results first, then record the transaction accepted at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_state = '0;
      expected_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          $error("result with no word outstanding: keystream %h state_out %h",
                 keystream_i, state_out_i);
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (keystream_i !== want.keystream) begin
            fail_count_o++;
            $error("keystream: expected %h, got %h", want.keystream, keystream_i);
          end
          if (state_out_i !== want.state_key) begin
            fail_count_o++;
            $error("state_out: expected %h, got %h", want.state_key, state_out_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        step = cipher_word(cipher_state, action_i, data_in_i, feed_back_i, key_in_i);
        cipher_state = step.lfsr;
        expected_q.push_back({step.keystream, gather_key(step.lfsr)});
      end
      pending_o = expected_q.size();
    end
  end

endmodule

### verif/tb_crypto1_word_cipher.sv
module tb_crypto1_word_cipher;
  import c1w_pkg::*;

  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam int unsigned WORDS_TOTAL = 1550;
  localparam int unsigned CYCLE_LIMIT = 200_000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [1:0]        action_i    = ACT_LOAD;
  logic [WORD_W-1:0] data_in_i   = '0;
  logic              feed_back_i = 1'b0;
  logic [KEY_W-1:0]  key_in_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [WORD_W-1:0] keystream_o;
  logic [KEY_W-1:0]  state_out_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycles        = 0;
  int unsigned words_sent    = 0;
  int unsigned n_load        = 0;
  int unsigned n_fwd         = 0;
  int unsigned n_back        = 0;
  int unsigned n_unused      = 0;
  int unsigned in_gap_pct    = 25;
  int unsigned out_stall_pct = 51;

  crypto1_word_cipher DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .data_in_i   (data_in_i),
    .feed_back_i (feed_back_i),
    .key_in_i    (key_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .keystream_o (keystream_o),
    .state_out_o (state_out_o)
  );

  crypto1_word_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .action_i     (action_i),
    .data_in_i    (data_in_i),
    .feed_back_i  (feed_back_i),
    .key_in_i     (key_in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .keystream_i  (keystream_o),
    .state_out_i  (state_out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d words outstanding", cycles, pending);
      $display("crypto1_word_cipher: mismatch");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return WORD_W'(1) << $urandom_range(WORD_W - 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return KEY_W'(1) << $urandom_range(KEY_W - 1);
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Offer one transaction at the falling edge and hold it until accepted
  task automatic send_word(input logic [1:0] act, input logic [WORD_W-1:0] data,
                           input logic fbk, input logic [KEY_W-1:0] key);
    if (words_sent < WORDS_TOTAL / 3) begin
      in_gap_pct    = 25;
      out_stall_pct = 51;
    end else if (words_sent < 2 * WORDS_TOTAL / 3) begin
      in_gap_pct    = 51;
      out_stall_pct = 25;
    end else begin
      in_gap_pct    = 0;
      out_stall_pct = 0;
    end
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    action_i    <= act;
    data_in_i   <= data;
    feed_back_i <= fbk;
    key_in_i    <= key;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    words_sent++;
    case (act)
      ACT_LOAD: n_load++;
      ACT_FWD:  n_fwd++;
      ACT_BACK: n_back++;
      default:  n_unused++;
    endcase
  endtask

  initial begin : stimulus
    logic [WORD_W-1:0] data;
    logic              fbk;
    logic [1:0]        dir;
    int unsigned       run_len;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: all-zero state, extreme keys and words, rollback undoing a forward word
    send_word(ACT_FWD,    '0,            1'b0, '0);
    send_word(ACT_BACK,   '1,            1'b1, '1);
    send_word(ACT_LOAD,   '1,            1'b1, '0);
    send_word(ACT_LOAD,   '0,            1'b0, '1);
    send_word(ACT_FWD,    '1,            1'b1, '0);
    send_word(ACT_BACK,   '1,            1'b1, '0);
    send_word(ACT_LOAD,   '0,            1'b0, 48'hAAAA_AAAA_AAAA);
    send_word(ACT_FWD,    '0,            1'b0, '1);
    send_word(ACT_BACK,   '0,            1'b0, '1);
    send_word(ACT_LOAD,   '1,            1'b0, 48'h5555_5555_5555);
    send_word(ACT_FWD,    32'h0123_4567, 1'b1, '0);
    send_word(ACT_UNUSED, 32'hDEAD_BEEF, 1'b1, '1);
    send_word(ACT_BACK,   32'h8000_0001, 1'b0, '0);
    send_word(ACT_LOAD,   '0,            1'b1, 48'h8000_0000_0001);
    send_word(ACT_FWD,    32'h0000_0001, 1'b1, '0);
    send_word(ACT_FWD,    32'h8000_0000, 1'b0, '0);
    send_word(ACT_BACK,   32'h8000_0000, 1'b0, '0);
    send_word(ACT_LOAD,   '0,            1'b0, 48'hA0A1_A2A3_A4A5);
    send_word(ACT_FWD,    32'hFFFF_0000, 1'b1, '0);
    send_word(ACT_BACK,   32'hFFFF_0000, 1'b1, '0);
    send_word(ACT_UNUSED, '0,            1'b0, '0);
    send_word(ACT_BACK,   32'h00FF_00FF, 1'b1, '1);

    // Random: mostly keyed sessions of forward/rollback words, some loose transactions
    while (words_sent < WORDS_TOTAL) begin
      if ($urandom_range(99) < 80) begin
        send_word(ACT_LOAD, rand_word(), 1'($urandom_range(1)), rand_key());
        run_len = $urandom_range(12, 2);
        for (int n = 0; n < run_len; n++) begin
          data = rand_word();
          fbk  = 1'($urandom_range(1));
          dir  = $urandom_range(1) ? ACT_FWD : ACT_BACK;
          send_word(dir, data, fbk, rand_key());
          // occasionally undo the word just applied
          if ($urandom_range(3) == 0) begin
            send_word((dir == ACT_FWD) ? ACT_BACK : ACT_FWD, data, fbk, rand_key());
          end
        end
      end else begin
        send_word(2'($urandom_range(3)), rand_word(), 1'($urandom_range(1)), rand_key());
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d words sent (%0d loads, %0d forward, %0d rollback, %0d unused action),",
             words_sent, n_load, n_fwd, n_back, n_unused);
    $display("%0d results checked across three sender/receiver stall profiles", checked);
    if (fail_count == 0) begin
      $display("crypto1_word_cipher: match");
    end else begin
      $display("crypto1_word_cipher: mismatch");
    end
    $finish;
  end

endmodule

### crypto1_word_cipher.f
src/c1w_pkg.sv
src/c1w_core.sv
src/crypto1_word_cipher.sv
verif/crypto1_word_checker.sv
verif/tb_crypto1_word_cipher.sv
